// File: sv/cds_pkg.sv
// ============================================================================
// cds_pkg
// Shared types, constants and calendar helpers for the calendar day stepper.
// ============================================================================
`default_nettype none

package cds_pkg;

    // Request command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FWD  = 2'd1;
    localparam logic [1:0] CMD_BWD  = 2'd2;

    // Limits
    localparam logic [15:0] YEAR_MAX   = 16'hFFFF;
    localparam logic [9:0]  MAX_STEP   = 10'd1023;
    localparam logic [3:0]  LAST_MONTH = 4'd11;
    localparam logic [2:0]  LAST_WDAY  = 3'd6;

    // Reset date: 1 Jan 1970, a Thursday
    localparam logic [15:0] RST_YEAR = 16'd1970;
    localparam logic [2:0]  RST_WDAY = 3'd4;

    // year / 25 as (year * RECIP25) >> RECIP_SHIFT, exact for 16-bit years
    localparam logic [16:0] RECIP25     = 17'd83887;
    localparam int          RECIP_SHIFT = 21;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // request taken, clear error flag
        logic load;     // latch load fields
        logic clamp;    // clamp day of year, start month search
        logic derive;   // one month of the month search
        logic step;     // move the date by one day
        logic bwd;      // step direction, 1 backward
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic derive_done; // current month holds the remaining days
        logic bound_hit;   // a step in the current direction is refused
    } t_dp_sts;

    // Days in a month, 0 January
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: sv/cds_ctrl.sv
// ============================================================================
// cds_ctrl
// Sequencer: takes a request, runs load / month search, day stepping or nothing
// (unused command), then holds the result until the output side takes it.
// ============================================================================
`default_nettype none

module cds_ctrl import cds_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_command,
    input  wire logic [9:0] i_day_count,
    input  wire logic       i_stall,
    input  wire t_dp_sts    i_sts,
    output logic            o_stall,
    output logic            o_valid,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_DERIVE,
        S_STEP,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [9:0]  r_count;
    logic        r_bwd;
    logic        w_accept;
    logic [9:0]  w_count_sat;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_count_sat = (i_day_count > MAX_STEP) ? MAX_STEP : i_day_count;

    // Datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        o_cmd.load   = w_accept && (i_command == CMD_LOAD);
        o_cmd.clamp  = (r_state == S_CLAMP);
        o_cmd.derive = (r_state == S_DERIVE);
        o_cmd.step   = (r_state == S_STEP) && (r_count != '0);
        o_cmd.bwd    = r_bwd;
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_bwd   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= w_count_sat;
                        r_bwd   <= (i_command == CMD_BWD);
                        case (i_command)
                            CMD_LOAD: r_state <= S_CLAMP;
                            CMD_FWD,
                            CMD_BWD:  r_state <= S_STEP;
                            default: begin
                                r_state <= S_DONE;
                                o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CLAMP: begin
                    r_state <= S_DERIVE;
                end
                S_DERIVE: begin
                    if (i_sts.derive_done) begin
                        r_state <= S_DONE;
                        o_valid <= 1'b1;
                    end
                end
                S_STEP: begin
                    if (r_count == '0 || i_sts.bound_hit) begin
                        r_state <= S_DONE;
                        o_valid <= 1'b1;
                    end else begin
                        r_count <= r_count - 10'd1;
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                        o_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/cds_dp.sv
// ============================================================================
// cds_dp
// Date registers with leap logic, one-day step unit and month search.
// ============================================================================
`default_nettype none

module cds_dp import cds_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [15:0] i_load_year,
    input  wire logic [8:0]  i_load_yday,
    input  wire logic [2:0]  i_load_weekday,
    output t_dp_sts          o_sts,
    output logic [15:0]      o_cur_year,
    output logic [8:0]       o_cur_yday,
    output logic [3:0]       o_cur_month,
    output logic [4:0]       o_cur_mday,
    output logic [2:0]       o_cur_weekday,
    output logic             o_range_error
);

    logic [15:0] r_year;
    logic [8:0]  r_yday;
    logic [3:0]  r_month;
    logic [4:0]  r_mday;
    logic [2:0]  r_wday;
    logic        r_err;
    logic [8:0]  r_rest;

    logic [32:0] w_prod;
    logic [11:0] w_q25;
    logic [15:0] w_q25x;
    logic [15:0] w_rem;
    logic [4:0]  w_r25;
    logic [15:0] w_year_m1;
    logic        w_leap;
    logic        w_leap_prev;
    logic [8:0]  w_last_yday;
    logic [4:0]  w_mlen;
    logic [4:0]  w_mlen_prev;
    logic [2:0]  w_wday_inc;
    logic [2:0]  w_wday_dec;

    // year mod 25 via reciprocal multiply
    assign w_prod = {17'd0, r_year} * {16'd0, RECIP25};
    assign w_q25  = w_prod[32:RECIP_SHIFT];
    assign w_q25x = {w_q25, 4'd0} + {1'b0, w_q25, 3'd0} + {4'd0, w_q25};
    assign w_rem  = r_year - w_q25x;
    assign w_r25  = w_rem[4:0];

    // Leap flags for this year and the one before
    assign w_year_m1   = r_year - 16'd1;
    assign w_leap      = (r_year[1:0] == 2'd0) && ((w_r25 != 5'd0) || (r_year[3:0] == 4'd0));
    assign w_leap_prev = (w_year_m1[1:0] == 2'd0)
                      && ((w_r25 != 5'd1) || (w_year_m1[3:0] == 4'd0));
    assign w_last_yday = w_leap ? 9'd365 : 9'd364;

    assign w_mlen      = month_len(r_month, w_leap);
    assign w_mlen_prev = month_len(r_month - 4'd1, w_leap);
    assign w_wday_inc  = (r_wday >= LAST_WDAY) ? 3'd0 : r_wday + 3'd1;
    assign w_wday_dec  = (r_wday == 3'd0) ? LAST_WDAY : r_wday - 3'd1;

    // Status
    assign o_sts.derive_done = (r_month == LAST_MONTH) || (r_rest < {4'd0, w_mlen});
    assign o_sts.bound_hit   = i_cmd.bwd ? ((r_yday == 9'd0) && (r_year == 16'd0))
                                         : ((r_yday >= w_last_yday) && (r_year == YEAR_MAX));

    // Date registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= RST_YEAR;
            r_yday  <= '0;
            r_month <= '0;
            r_mday  <= '0;
            r_wday  <= RST_WDAY;
            r_err   <= 1'b0;
            r_rest  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_err <= 1'b0;
            end
            if (i_cmd.load) begin
                r_year <= i_load_year;
                r_yday <= i_load_yday;
                r_wday <= (i_load_weekday == 3'd7) ? 3'd0 : i_load_weekday;
            end
            // Clamp to the last day of the loaded year
            if (i_cmd.clamp) begin
                r_month <= '0;
                if (r_yday > w_last_yday) begin
                    r_yday <= w_last_yday;
                    r_rest <= w_last_yday;
                end else begin
                    r_rest <= r_yday;
                end
            end
            // Month search, one month per cycle
            if (i_cmd.derive) begin
                if (o_sts.derive_done) begin
                    r_mday <= r_rest[4:0];
                end else begin
                    r_rest  <= r_rest - {4'd0, w_mlen};
                    r_month <= r_month + 4'd1;
                end
            end
            // One day step
            if (i_cmd.step) begin
                if (o_sts.bound_hit) begin
                    r_err <= 1'b1;
                end else if (!i_cmd.bwd) begin
                    r_wday <= w_wday_inc;
                    if (r_yday >= w_last_yday) begin
                        r_year  <= r_year + 16'd1;
                        r_yday  <= '0;
                        r_month <= '0;
                        r_mday  <= '0;
                    end else begin
                        r_yday <= r_yday + 9'd1;
                        if (r_mday == w_mlen - 5'd1) begin
                            r_month <= r_month + 4'd1;
                            r_mday  <= '0;
                        end else begin
                            r_mday <= r_mday + 5'd1;
                        end
                    end
                end else begin
                    r_wday <= w_wday_dec;
                    if (r_yday == 9'd0) begin
                        r_year  <= w_year_m1;
                        r_yday  <= w_leap_prev ? 9'd365 : 9'd364;
                        r_month <= LAST_MONTH;
                        r_mday  <= 5'd30;
                    end else begin
                        r_yday <= r_yday - 9'd1;
                        if (r_mday == 5'd0) begin
                            r_month <= r_month - 4'd1;
                            r_mday  <= w_mlen_prev - 5'd1;
                        end else begin
                            r_mday <= r_mday - 5'd1;
                        end
                    end
                end
            end
        end
    end

    assign o_cur_year    = r_year;
    assign o_cur_yday    = r_yday;
    assign o_cur_month   = r_month;
    assign o_cur_mday    = r_mday;
    assign o_cur_weekday = r_wday;
    assign o_range_error = r_err;

endmodule

`default_nettype wire

// File: sv/calendar_day_stepper.sv
// ============================================================================
// calendar_day_stepper
// Gregorian date keeper: load a date, or step it forward or backward by a
// number of days, one day per clock.
// ============================================================================
//  channel   handshake            payload
//  request   i_valid / o_stall    i_command, i_day_count, i_load_year,
//                                 i_load_yday, i_load_weekday
//  result    o_valid / i_stall    o_cur_year, o_cur_yday, o_cur_month,
//                                 o_cur_mday, o_cur_weekday, o_range_error
//
//  Step request: one day per cycle through the step unit.
//  Load request: the month search takes one month per cycle.
//  Unused command: result in the cycle after accept.
//  One request at a time: o_stall is high from accept until the result is taken.
//  Synchronous active-low reset sets Thursday 1 Jan 1970.
// ============================================================================
`default_nettype none

module calendar_day_stepper import cds_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_day_count,
    input  wire logic [15:0] i_load_year,
    input  wire logic [8:0]  i_load_yday,
    input  wire logic [2:0]  i_load_weekday,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_cur_year,
    output logic [8:0]       o_cur_yday,
    output logic [3:0]       o_cur_month,
    output logic [4:0]       o_cur_mday,
    output logic [2:0]       o_cur_weekday,
    output logic             o_range_error
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    cds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_day_count (i_day_count),
        .i_stall     (i_stall),
        .i_sts       (w_sts),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (w_cmd)
    );

    // Date datapath
    cds_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_load_year    (i_load_year),
        .i_load_yday    (i_load_yday),
        .i_load_weekday (i_load_weekday),
        .o_sts          (w_sts),
        .o_cur_year     (o_cur_year),
        .o_cur_yday     (o_cur_yday),
        .o_cur_month    (o_cur_month),
        .o_cur_mday     (o_cur_mday),
        .o_cur_weekday  (o_cur_weekday),
        .o_range_error  (o_range_error)
    );

endmodule

`default_nettype wire

// File: sv/cds_checker.sv
// ============================================================================
// cds_checker
// Port-level checks for the calendar day stepper, bound to the top level.
// ============================================================================
`default_nettype none

module cds_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_stall,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [15:0] o_cur_year,
    input  wire logic [8:0]  o_cur_yday,
    input  wire logic [3:0]  o_cur_month,
    input  wire logic [4:0]  o_cur_mday,
    input  wire logic [2:0]  o_cur_weekday,
    input  wire logic        o_range_error
);

    // A held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cur_year) && $stable(o_cur_yday)
            && $stable(o_cur_month) && $stable(o_cur_mday) && $stable(o_cur_weekday)
            && $stable(o_range_error))
        else $error("result changed while stalled");

    // Reported date fields are in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cur_yday <= 9'd365) && (o_cur_month <= 4'd11)
            && (o_cur_mday <= 5'd30) && (o_cur_weekday <= 3'd6))
        else $error("date field out of range");

    // No new request while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request side open while result pending");

    // A refused step stops at a year bound
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |->
            (o_cur_year == 16'hFFFF && o_cur_yday >= 9'd364)
            || (o_cur_year == 16'd0 && o_cur_yday == 9'd0))
        else $error("range error away from a year bound");

    // No result in the first cycle out of reset
    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind calendar_day_stepper cds_checker u_cds_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for calendar_day_stepper. A directed table covers reset,
// year bounds, load clamping, leap rules and the unused command; random load
// and step sequences follow. Results are checked against typed-in dates or the
// bench's own date predictor, under changing sender and receiver idle patterns.
// ============================================================================

module testbench import cds_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused command code: reports the current date
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int N_RANDOM       = 560;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 12000; // cycles with no handshake at all
    localparam int END_DRAIN      = 1100;  // longest step latency plus margin

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  count;
        logic [15:0] year;
        logic [8:0]  yday;
        logic [2:0]  wday;
    } t_day_req;

    typedef struct packed {
        logic [15:0] year;
        logic [8:0]  yday;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        logic        range_err;
    } t_date_rpt;

    typedef struct packed {
        t_day_req  req;
        logic      chk;   // 1: use the typed-in date, not the predictor
        t_date_rpt want;
    } t_vector;

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = '0;
    logic [9:0]  i_day_count = '0;
    logic [15:0] i_load_year = '0;
    logic [8:0]  i_load_yday = '0;
    logic [2:0]  i_load_weekday = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_cur_year;
    logic [8:0]  o_cur_yday;
    logic [3:0]  o_cur_month;
    logic [4:0]  o_cur_mday;
    logic [2:0]  o_cur_weekday;
    logic        o_range_error;

    // Predictor state
    logic [15:0] cal_year = RST_YEAR;
    logic [8:0]  cal_yday = 9'd0;
    logic [2:0]  cal_wday = RST_WDAY;

    t_date_rpt pending_dates[$];
    t_vector   directed[$];

    int errors       = 0;
    int checked      = 0;
    int bound_hits   = 0;
    int quiet_cycles = 0;
    int snd_idle_pct = 29;
    int rcv_idle_pct = 63;
    int hold_left    = 0;
    bit hold_start   = 1'b0;
    int req_count[4] = '{default: 0};

    calendar_day_stepper uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_day_count    (i_day_count),
        .i_load_year    (i_load_year),
        .i_load_yday    (i_load_yday),
        .i_load_weekday (i_load_weekday),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cur_year     (o_cur_year),
        .o_cur_yday     (o_cur_yday),
        .o_cur_month    (o_cur_month),
        .o_cur_mday     (o_cur_mday),
        .o_cur_weekday  (o_cur_weekday),
        .o_range_error  (o_range_error)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Gregorian leap rule; year 0 is leap
    function automatic bit leap_year(input logic [15:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [8:0] days_in_year(input logic [15:0] y);
        return leap_year(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic int days_in_month(input int m, input bit leap);
        case (m)
            1:           return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    // Apply one request to the predicted date and report the outcome
    function automatic t_date_rpt advance_date(input t_day_req r);
        t_date_rpt rpt;
        int        steps;
        int        rest;
        int        m;
        logic      err;
        err   = 1'b0;
        steps = (r.count > MAX_STEP) ? int'(MAX_STEP) : int'(r.count);
        case (r.cmd)
            CMD_LOAD: begin
                cal_year = r.year;
                cal_yday = (r.yday >= days_in_year(r.year)) ?
                           days_in_year(r.year) - 9'd1 : r.yday;
                cal_wday = (r.wday == 3'd7) ? 3'd0 : r.wday;
            end
            CMD_FWD: begin
                for (int i = 0; i < steps; i++) begin
                    if (int'(cal_yday) + 1 >= int'(days_in_year(cal_year))) begin
                        if (cal_year == YEAR_MAX) begin
                            err = 1'b1;
                            break;
                        end
                        cal_year = cal_year + 16'd1;
                        cal_yday = 9'd0;
                    end else begin
                        cal_yday = cal_yday + 9'd1;
                    end
                    cal_wday = (cal_wday == LAST_WDAY) ? 3'd0 : cal_wday + 3'd1;
                end
            end
            CMD_BWD: begin
                for (int i = 0; i < steps; i++) begin
                    if (cal_yday == 9'd0) begin
                        if (cal_year == 16'd0) begin
                            err = 1'b1;
                            break;
                        end
                        cal_year = cal_year - 16'd1;
                        cal_yday = days_in_year(cal_year) - 9'd1;
                    end else begin
                        cal_yday = cal_yday - 9'd1;
                    end
                    cal_wday = (cal_wday == 3'd0) ? LAST_WDAY : cal_wday - 3'd1;
                end
            end
            default: ;
        endcase

        // Month search from the day of year
        rest = int'(cal_yday);
        m    = 0;
        while (m < 11 && rest >= days_in_month(m, leap_year(cal_year))) begin
            rest -= days_in_month(m, leap_year(cal_year));
            m++;
        end

        rpt.year      = cal_year;
        rpt.yday      = cal_yday;
        rpt.month     = 4'(m);
        rpt.mday      = 5'(rest);
        rpt.wday      = cal_wday;
        rpt.range_err = err;
        return rpt;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [9:0] cnt,
                           input logic [15:0] y, input logic [8:0] d,
                           input logic [2:0] w, input logic chk, input t_date_rpt want);
        directed.push_back({cmd, cnt, y, d, w, chk, want});
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Offer one request from a falling edge; returns at the falling edge after
    // it was taken
    task automatic issue_request(input t_day_req r, input logic chk, input t_date_rpt want);
        t_date_rpt pred;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_command      = r.cmd;
        i_day_count    = r.count;
        i_load_year    = r.year;
        i_load_yday    = r.yday;
        i_load_weekday = r.wday;
        do @(posedge i_clk); while (o_stall);
        pred = advance_date(r);
        pending_dates.push_back(chk ? want : pred);
        req_count[r.cmd]++;
        @(negedge i_clk);
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        i_stall = (hold_left > 0) || ($urandom_range(0, 99) < rcv_idle_pct);
        if (hold_left > 0)
            hold_left--;
    end

    // Result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_dates.size() == 0) begin
                    $display("%0t: result with no request outstanding", $time);
                    errors++;
                end else begin
                    t_date_rpt want;
                    want = pending_dates.pop_front();
                    check_field("cur_year",    want.year,      o_cur_year);
                    check_field("cur_yday",    want.yday,      o_cur_yday);
                    check_field("cur_month",   want.month,     o_cur_month);
                    check_field("cur_mday",    want.mday,      o_cur_mday);
                    check_field("cur_weekday", want.wday,      o_cur_weekday);
                    check_field("range_error", want.range_err, o_range_error);
                    checked++;
                    if (o_range_error)
                        bound_hits++;
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_day_req r;
        int       seq_left;
        int       n;
        int       pick;
        seq_left = 0;

        // Directed table: typed dates where they are obvious
        add_row(CMD_NONE, 10'd0,    16'd0,     9'd0,   3'd0, 1'b1,
                {16'd1970, 9'd0, 4'd0, 5'd0, 3'd4, 1'b0});
        add_row(CMD_FWD,  10'd0,    16'd0,     9'd0,   3'd0, 1'b1,
                {16'd1970, 9'd0, 4'd0, 5'd0, 3'd4, 1'b0});
        add_row(CMD_LOAD, 10'd1023, 16'hFFFF,  9'd511, 3'd7, 1'b1,
                {16'd65535, 9'd364, 4'd11, 5'd30, 3'd0, 1'b0});
        add_row(CMD_FWD,  10'd1023, 16'd0,     9'd0,   3'd0, 1'b1,
                {16'd65535, 9'd364, 4'd11, 5'd30, 3'd0, 1'b1});
        add_row(CMD_BWD,  10'd1,    16'd0,     9'd0,   3'd0, 1'b1,
                {16'd65535, 9'd363, 4'd11, 5'd29, 3'd6, 1'b0});
        add_row(CMD_LOAD, 10'd0,    16'd0,     9'd365, 3'd6, 1'b1,
                {16'd0, 9'd365, 4'd11, 5'd30, 3'd6, 1'b0});
        add_row(CMD_LOAD, 10'd0,    16'd0,     9'd0,   3'd0, 1'b1,
                {16'd0, 9'd0, 4'd0, 5'd0, 3'd0, 1'b0});
        add_row(CMD_BWD,  10'd1023, 16'd0,     9'd0,   3'd0, 1'b1,
                {16'd0, 9'd0, 4'd0, 5'd0, 3'd0, 1'b1});
        add_row(CMD_FWD,  10'd1,    16'd0,     9'd0,   3'd0, 1'b1,
                {16'd0, 9'd1, 4'd0, 5'd1, 3'd1, 1'b0});
        add_row(CMD_LOAD, 10'd0,    16'd2000,  9'd59,  3'd2, 1'b1,
                {16'd2000, 9'd59, 4'd1, 5'd28, 3'd2, 1'b0});
        add_row(CMD_LOAD, 10'd0,    16'd1900,  9'd365, 3'd3, 1'b1,
                {16'd1900, 9'd364, 4'd11, 5'd30, 3'd3, 1'b0});
        // Leap day boundaries in leap and century years, and a year rollover
        add_row(CMD_FWD,  10'd1,    16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_LOAD, 10'd0,    16'd2100,  9'd58,  3'd1, 1'b0, '0);
        add_row(CMD_FWD,  10'd1,    16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_LOAD, 10'd0,    16'd2024,  9'd365, 3'd0, 1'b0, '0);
        add_row(CMD_FWD,  10'd1,    16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_BWD,  10'd1,    16'd0,     9'd0,   3'd0, 1'b0, '0);
        // Run into the upper bound part way through a step
        add_row(CMD_LOAD, 10'd0,    16'd65534, 9'd360, 3'd5, 1'b0, '0);
        add_row(CMD_FWD,  10'd10,   16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_FWD,  10'd1023, 16'd0,     9'd0,   3'd0, 1'b0, '0);
        // Run into the lower bound part way through a step
        add_row(CMD_LOAD, 10'd0,    16'd1,     9'd3,   3'd4, 1'b0, '0);
        add_row(CMD_BWD,  10'd10,   16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_BWD,  10'd500,  16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_NONE, 10'd0,    16'd0,     9'd0,   3'd0, 1'b0, '0);
        add_row(CMD_LOAD, 10'd0,    16'd1970,  9'd0,   3'd4, 1'b0, '0);

        // Hold reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[k])
            issue_request(directed[k].req, directed[k].chk, directed[k].want);

        for (n = 0; n < N_RANDOM; n++) begin
            // Idle pattern per third of the random part
            if (n == N_RANDOM / 3) begin
                snd_idle_pct = 63;
                rcv_idle_pct = 29;
            end else if (n == 2 * N_RANDOM / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            // Long receiver hold-off while requests keep coming
            if (n == 100 || n == 450)
                hold_start = 1'b1;

            // Sender waits for the block to drain completely
            if (n == 300) begin
                i_valid = 1'b0;
                while (pending_dates.size() != 0)
                    @(negedge i_clk);
            end

            r.count = 10'($urandom_range(0, 1023));
            r.year  = 16'($urandom);
            r.yday  = 9'($urandom);
            r.wday  = 3'($urandom);
            if (seq_left == 0 && $urandom_range(0, 99) < 75) begin
                // Start of a sequence: load a date near an interesting edge
                r.cmd = CMD_LOAD;
                case ($urandom_range(0, 4))
                    0:       r.year = 16'($urandom_range(0, 3));
                    1:       r.year = 16'hFFFF - 16'($urandom_range(0, 3));
                    2:       r.year = 16'($urandom_range(0, 655) * 100);
                    3:       r.year = 16'($urandom_range(1580, 2420));
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0:       r.yday = 9'($urandom_range(360, 365));
                    1:       r.yday = 9'($urandom_range(0, 5));
                    2:       r.yday = 9'($urandom_range(0, 365));
                    default: ;
                endcase
                seq_left = $urandom_range(1, 6);
            end else begin
                // Step within a sequence, or noise outside one
                if (seq_left > 0) begin
                    r.cmd = ($urandom_range(0, 1) == 0) ? CMD_FWD : CMD_BWD;
                    seq_left--;
                end else begin
                    r.cmd = 2'($urandom_range(0, 3));
                end
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    r.count = 10'($urandom_range(0, 40));
                else if (pick < 97)
                    r.count = 10'($urandom_range(0, 400));
                else
                    r.count = 10'($urandom_range(900, 1023));
            end
            issue_request(r, 1'b0, '0);
        end

        // Drain
        i_valid = 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);

        $display("covered %0d loads, %0d forward, %0d backward, %0d unused-command requests",
                 req_count[CMD_LOAD], req_count[CMD_FWD], req_count[CMD_BWD],
                 req_count[CMD_NONE]);
        $display("%0d results checked, %0d stopped at a year bound, %0d mismatches",
                 checked, bound_hits, errors);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
